[sv/lagged_fibonacci_random_defines.svh]
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator: assertion macros
// Shared property forms for the checkers of this block.
// ----------------------------------------------------------------------------
`ifndef LAGGED_FIBONACCI_RANDOM_DEFINES_SVH
`define LAGGED_FIBONACCI_RANDOM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lagged_fibonacci_random: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define LFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lagged_fibonacci_random: next-cycle property failed");

`endif

[sv/lfr_pkg.sv]
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator: package
// Widths, lags, seed table and index helpers of the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfr_pkg;

	localparam int LONG_LAG    = 17;
	localparam int SHORT_START = 5;
	localparam int TABLE_DEPTH = LONG_LAG + 1;
	localparam int WORD_W      = 32;
	localparam int IDX_W       = 5;
	localparam int DIV_STEPS   = WORD_W;
	localparam int CNT_W       = $clog2(DIV_STEPS + 1);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [TABLE_DEPTH-1:0][WORD_W-1:0] seed_arr_t;

	function automatic seed_arr_t seed_table();
		seed_arr_t s;
		s = '0;
		s[LONG_LAG]     = word_t'(1);
		s[LONG_LAG - 1] = word_t'(2);
		for (int n = LONG_LAG - 2; n >= 0; n--) begin
			s[n] = s[n + 1] + s[n + 2];
		end
		return s;
	endfunction

	localparam seed_arr_t SEED = seed_table();

	function automatic idx_t clamp_slot(input idx_t ix);
		if (ix == '0 || ix > idx_t'(LONG_LAG)) begin
			return idx_t'(LONG_LAG);
		end
		return ix;
	endfunction

	function automatic idx_t step_down(input idx_t ix);
		idx_t nx;
		nx = clamp_slot(ix) - idx_t'(1);
		if (nx == '0) begin
			nx = idx_t'(LONG_LAG);
		end
		return nx;
	endfunction

endpackage

[sv/lagged_fibonacci_random.sv]
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator
// Additive generator with lags 17 and 5 over a table memory, returning each
// new sum reduced by the modulus of the request, or zero for a zero modulus.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  request   in         req_valid/req_stall   modulus [31:0]
//  response  out        rsp_valid/rsp_stall   value   [31:0]
//
//  A transaction passes from request to response through a table read,
//  an add and write-back, 32 steps of the bit-serial remainder unit and the
//  load of the output register, which waits while a response is stalled.
//  Reset restores the seed table at once through per-entry valid bits.
//  A stalled response is held while the next request is already taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lagged_fibonacci_random (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [31:0]           modulus,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic [31:0]           value
);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DIV, ST_DONE} state_t;

	state_t                          state_q;
	lfr_pkg::idx_t                   long_idx_q;
	lfr_pkg::idx_t                   short_idx_q;
	logic [lfr_pkg::TABLE_DEPTH-1:0] entry_valid_q;
	lfr_pkg::word_t                  rem_q;
	lfr_pkg::word_t                  dvd_q;
	lfr_pkg::word_t                  mod_q;
	lfr_pkg::cnt_t                   cnt_q;
	lfr_pkg::word_t                  value_q;
	logic                            rsp_valid_q;

	lfr_pkg::word_t lag_mem [lfr_pkg::TABLE_DEPTH];
	lfr_pkg::word_t rd_a_s1;
	lfr_pkg::word_t rd_b_s1;
	lfr_pkg::idx_t  addr_a_s1;
	lfr_pkg::idx_t  addr_b_s1;
	logic           ok_a_s1;
	logic           ok_b_s1;

	logic           accept;
	logic           rsp_load;
	lfr_pkg::idx_t  long_slot;
	lfr_pkg::idx_t  short_slot;
	lfr_pkg::word_t op_a;
	lfr_pkg::word_t op_b;
	lfr_pkg::word_t sum;
	logic [32:0]    rem_sh;
	logic [32:0]    rem_sub;
	logic           rem_ge;
	lfr_pkg::word_t rem_nx;

	assign req_stall  = (state_q != ST_IDLE);
	assign accept     = req_valid && !req_stall;
	assign rsp_load   = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign long_slot  = lfr_pkg::clamp_slot(long_idx_q);
	assign short_slot = lfr_pkg::clamp_slot(short_idx_q);
	assign rsp_valid  = rsp_valid_q;
	assign value      = value_q;

	always_comb begin
		op_a    = ok_a_s1 ? rd_a_s1 : lfr_pkg::SEED[addr_a_s1];
		op_b    = ok_b_s1 ? rd_b_s1 : lfr_pkg::SEED[addr_b_s1];
		sum     = op_a + op_b;
		rem_sh  = {rem_q, dvd_q[lfr_pkg::WORD_W-1]};
		rem_sub = rem_sh - {1'b0, mod_q};
		rem_ge  = (rem_sh >= {1'b0, mod_q});
		rem_nx  = rem_ge ? rem_sub[lfr_pkg::WORD_W-1:0] : rem_sh[lfr_pkg::WORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			lag_mem[addr_a_s1] <= sum;
		end
		if (accept) begin
			rd_a_s1   <= lag_mem[long_slot];
			rd_b_s1   <= lag_mem[short_slot];
			addr_a_s1 <= long_slot;
			addr_b_s1 <= short_slot;
			ok_a_s1   <= entry_valid_q[long_slot];
			ok_b_s1   <= entry_valid_q[short_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			long_idx_q    <= lfr_pkg::idx_t'(lfr_pkg::LONG_LAG);
			short_idx_q   <= lfr_pkg::idx_t'(lfr_pkg::SHORT_START);
			entry_valid_q <= '0;
			rem_q         <= '0;
			dvd_q         <= '0;
			mod_q         <= '0;
			cnt_q         <= '0;
			value_q       <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mod_q   <= modulus;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					entry_valid_q[addr_a_s1] <= 1'b1;
					long_idx_q  <= lfr_pkg::step_down(long_idx_q);
					short_idx_q <= lfr_pkg::step_down(short_idx_q);
					dvd_q       <= sum;
					rem_q       <= '0;
					cnt_q       <= lfr_pkg::cnt_t'(lfr_pkg::DIV_STEPS);
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_nx;
					dvd_q <= {dvd_q[lfr_pkg::WORD_W-2:0], 1'b0};
					cnt_q <= cnt_q - lfr_pkg::cnt_t'(1);
					if (cnt_q == lfr_pkg::cnt_t'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						value_q <= (mod_q == '0) ? '0 : rem_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/lfr_checker.sv]
// ----------------------------------------------------------------------------
// Lagged Fibonacci random generator: port checker
// Watches the handshakes of the generator and is bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lagged_fibonacci_random_defines.svh"

module lfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] value
);

	// A stalled response stays offered with the same value.
	`LFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
	`LFR_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(value))
	// Only one request is worked on at a time.
	`LFR_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)
	// Whenever a new response appears, the generator is free again.
	`LFR_ASSERT_SAME(a_free_on_result, $rose(rsp_valid), !req_stall)

endmodule

bind lagged_fibonacci_random lfr_checker u_lfr_checker (.*);
